FILE: src/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg: shared constants and types for the stack command engine
// Command and status codes, stack sizing, and the control and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_LIST = 3'd1;
    localparam logic [2:0] CMD_PEEK = 3'd2;
    localparam logic [2:0] CMD_POP  = 3'd3;
    localparam logic [2:0] CMD_SWAP = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NOARG = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_SHORT = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic       push;      // write value at count, count + 1
        logic       pop;       // count - 1
        logic       rd_top;    // read top two entries, list index = top
        logic       rd_next;   // list index - 1, read that entry
        logic       wr_hi;     // top entry <= second entry (read copy)
        logic       wr_lo;     // second entry <= top entry (read copy)
        logic       out_load;  // load the output register
        logic [2:0] out_status;
        logic       out_has_data;
        logic       out_last;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;     // no entries
        logic short_stk; // fewer than two entries
        logic full;      // count at depth
        logic idx_zero;  // list index at bottom entry
        logic out_free;  // output register can take a word this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/sce_dp.sv
// ----------------------------------------------------------------------------
// sce_dp: stack datapath
// Stack memory with one write port and two registered read ports, the entry
// count, the list index, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sce_pkg::dp_cmd_t              cmd,
    output sce_pkg::dp_stat_t                  stat,
    input  wire logic signed [31:0]            value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic                               has_data,
    output logic signed [31:0]                 data,
    output logic                               last
);
    import sce_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg;
    logic              has_data_reg;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;

    logic [CNT_W-1:0]  top_cnt, sec_cnt;
    logic [ADDR_W-1:0] top_addr, sec_addr, idx_dec;
    logic [ADDR_W-1:0] rd_a_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en, rd_en;

    // Address arithmetic
    assign top_cnt  = count_reg - CNT_W'(1);
    assign sec_cnt  = count_reg - CNT_W'(2);
    assign top_addr = top_cnt[ADDR_W-1:0];
    assign sec_addr = sec_cnt[ADDR_W-1:0];
    assign idx_dec  = idx_reg - ADDR_W'(1);

    // Status back to the controller
    assign stat.empty     = (count_reg == '0);
    assign stat.short_stk = (count_reg < CNT_W'(2));
    assign stat.full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // Memory port selection
    always_comb
    begin
        wr_en     = cmd.push || cmd.wr_hi || cmd.wr_lo;
        wr_addr   = top_addr;
        wr_data   = rd_b_reg;
        rd_en     = cmd.rd_top || cmd.rd_next;
        rd_a_addr = cmd.rd_top ? top_addr : idx_dec;
        if (cmd.push)
        begin
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = value;
        end
        else if (cmd.wr_lo)
        begin
            wr_addr = sec_addr;
            wr_data = rd_a_reg;
        end
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory read ports, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[sec_addr];
        end
    end

    // Count, list index and output valid
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = top_cnt;
        end

        idx_next = idx_reg;
        if (cmd.rd_top)
        begin
            idx_next = top_addr;
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_dec;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg   <= cmd.out_status;
            has_data_reg <= cmd.out_has_data;
            data_reg     <= cmd.out_has_data ? rd_a_reg : '0;
            last_reg     <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign has_data  = has_data_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < CNT_W'(STACK_DEPTH)))
        else $error("push issued on full stack");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop issued on empty stack");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

FILE: src/sce_ctrl.sv
// ----------------------------------------------------------------------------
// sce_ctrl: stack command controller
// Decodes each command word, sequences memory reads, swap writes and list
// output, and holds a pending result while the output register is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [2:0]    cmd_code,
    input  wire logic          has_value,
    input  wire sce_pkg::dp_stat_t stat,
    output sce_pkg::dp_cmd_t   dp
);
    import sce_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SWAP1  = 3'd2;
    localparam logic [2:0] S_SWAP2  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] res_status_reg, res_status_next;
    logic       list_reg, list_next;

    logic       imm;
    logic [2:0] imm_status;

    // Next state and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        list_next       = list_reg;
        dp              = '0;
        imm             = 1'b0;
        imm_status      = ST_OK;
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_code)
                        CMD_PUSH:
                        begin
                            imm = 1'b1;
                            if (!has_value)
                            begin
                                imm_status = ST_NOARG;
                            end
                            else if (stat.full)
                            begin
                                imm_status = ST_FULL;
                            end
                            else
                            begin
                                dp.push = 1'b1;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (stat.empty)
                            begin
                                imm = 1'b1;
                            end
                            else
                            begin
                                dp.rd_top  = 1'b1;
                                list_next  = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                imm        = 1'b1;
                                imm_status = ST_EMPTY;
                            end
                            else
                            begin
                                dp.rd_top  = 1'b1;
                                list_next  = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        CMD_POP:
                        begin
                            imm = 1'b1;
                            if (stat.empty)
                            begin
                                imm_status = ST_EMPTY;
                            end
                            else
                            begin
                                dp.pop = 1'b1;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (stat.short_stk)
                            begin
                                imm        = 1'b1;
                                imm_status = ST_SHORT;
                            end
                            else
                            begin
                                dp.rd_top  = 1'b1;
                                state_next = S_SWAP1;
                            end
                        end
                        default:
                        begin
                            // unknown command: dropped without a result
                        end
                    endcase

                    // single-word result: send now or park it
                    if (imm)
                    begin
                        if (stat.out_free)
                        begin
                            dp.out_load   = 1'b1;
                            dp.out_status = imm_status;
                            dp.out_last   = 1'b1;
                        end
                        else
                        begin
                            res_status_next = imm_status;
                            state_next      = S_RESULT;
                        end
                    end
                end
            end
            S_READ:
            begin
                // one word per entry read; peek stops after the first
                if (stat.out_free)
                begin
                    dp.out_load     = 1'b1;
                    dp.out_status   = ST_OK;
                    dp.out_has_data = 1'b1;
                    dp.out_last     = !list_reg || stat.idx_zero;
                    if (!list_reg || stat.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dp.rd_next = 1'b1;
                    end
                end
            end
            S_SWAP1:
            begin
                dp.wr_hi   = 1'b1;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                dp.wr_lo        = 1'b1;
                res_status_next = ST_OK;
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    dp.out_load   = 1'b1;
                    dp.out_status = res_status_reg;
                    dp.out_last   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            list_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            list_reg       <= list_next;
        end
    end

    // Checks
    a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP1) |=> (state_reg == S_SWAP2))
        else $error("swap write sequence broken");

    a_swap_rd: assert property (@(posedge clk) disable iff (!rst_n)
        dp.rd_top && (state_reg == S_IDLE) && (cmd_code == CMD_SWAP)
        |=> (state_reg == S_SWAP1))
        else $error("swap read not followed by write");

    a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp.push, dp.pop, dp.rd_top, dp.rd_next, dp.wr_hi, dp.wr_lo}))
        else $error("conflicting datapath operations");

endmodule

`default_nettype wire

FILE: src/stack_command_engine.sv
// ----------------------------------------------------------------------------
// stack_command_engine: bounded LIFO stack of signed 32-bit values
// Executes push, list all, peek, pop and swap commands and returns status
// words; list all returns one word per entry from top to bottom (one if empty).
// ----------------------------------------------------------------------------
// Timing: push, pop and every error return their word in the cycle after
// the command is taken if the output register is free, and the next command
// may follow at once; else the word waits and the input stalls. Peek waits
// on the registered memory read port. Swap reads both top entries, then
// writes twice through the single write port, then returns the result. List
// all reads the top entry, then returns one word per entry while the output
// is not stalled. The input also stalls while a peek, swap or list all runs;
// a finished word may wait in the output register while the next command is
// taken. Memory is not cleared at reset; only entries pushed are read.
`default_nettype none

module stack_command_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         cmd,
    input  wire logic               has_value,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic                    has_data,
    output logic signed [31:0]      data,
    output logic                    last
);
    import sce_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    sce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd_code  (cmd),
        .has_value (has_value),
        .stat      (dp_stat),
        .dp        (dp_cmd)
    );

    sce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .has_data  (has_data),
        .data      (data),
        .last      (last)
    );

endmodule

`default_nettype wire

FILE: tb/stack_command_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_command_engine_tb: self-checking bench for the stack command engine
// Drives push, list, peek, pop, swap and unused command codes through the
// valid/stall input port. A shadow stack predicts every result word, and each
// word taken from the output port is compared field by field, in order. A
// directed table opens the run, then a fill past full and a list of the full
// stack under a long output hold, then random rounds. Ports idle at random.
// ----------------------------------------------------------------------------

module stack_command_engine_tb;

    import sce_pkg::*;

    // Unused command codes, ignored by the block
    localparam logic [2:0] CMD_BAD5 = 3'd5;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;

    localparam int COMMAND_TARGET = 430;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 30;
    localparam int CYCLE_LIMIT    = 1_200_000;

    // One result word
    typedef struct packed {
        logic [2:0]         status;
        logic               has_data;
        logic signed [31:0] data;
        logic               last;
    } word_t;

    // One row of the opening command table
    typedef struct packed {
        logic [2:0]  op;
        logic        hv;
        logic [31:0] val;
        logic        pin;   // want holds the typed-in expected word
        word_t       want;
    } row_t;

    localparam word_t W_NONE  = '0;
    localparam word_t W_OK    = '{ST_OK,    1'b0, 32'sd0, 1'b1};
    localparam word_t W_NOARG = '{ST_NOARG, 1'b0, 32'sd0, 1'b1};
    localparam word_t W_EMPTY = '{ST_EMPTY, 1'b0, 32'sd0, 1'b1};
    localparam word_t W_SHORT = '{ST_SHORT, 1'b0, 32'sd0, 1'b1};
    localparam word_t W_MAX   = '{ST_OK,    1'b1, 32'sh7FFF_FFFF, 1'b1};
    localparam word_t W_MIN   = '{ST_OK,    1'b1, 32'sh8000_0000, 1'b1};

    localparam int ROW_COUNT = 25;
    localparam row_t OPENING_ROWS [ROW_COUNT] = '{
        '{CMD_PEEK, 1'b0, 32'h0000_0000, 1'b1, W_EMPTY},
        '{CMD_POP,  1'b1, 32'h1234_5678, 1'b1, W_EMPTY},
        '{CMD_SWAP, 1'b0, 32'h0000_0000, 1'b1, W_SHORT},
        '{CMD_LIST, 1'b0, 32'h0000_0000, 1'b1, W_OK},
        '{CMD_PUSH, 1'b0, 32'h7FFF_FFFF, 1'b1, W_NOARG},
        '{CMD_BAD5, 1'b1, 32'hFFFF_FFFF, 1'b0, W_NONE},
        '{CMD_BAD7, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_PUSH, 1'b1, 32'h7FFF_FFFF, 1'b1, W_OK},
        '{CMD_SWAP, 1'b1, 32'h0000_0000, 1'b1, W_SHORT},
        '{CMD_PEEK, 1'b0, 32'h0000_0000, 1'b1, W_MAX},
        '{CMD_LIST, 1'b0, 32'h0000_0000, 1'b1, W_MAX},
        '{CMD_PUSH, 1'b1, 32'h8000_0000, 1'b1, W_OK},
        '{CMD_PEEK, 1'b0, 32'hFFFF_FFFF, 1'b1, W_MIN},
        '{CMD_SWAP, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_LIST, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_PUSH, 1'b1, 32'hFFFF_FFFF, 1'b0, W_NONE},
        '{CMD_PUSH, 1'b1, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_BAD6, 1'b1, 32'hAAAA_AAAA, 1'b0, W_NONE},
        '{CMD_POP,  1'b0, 32'h5555_5555, 1'b1, W_OK},
        '{CMD_LIST, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_PUSH, 1'b0, 32'hFFFF_FFFF, 1'b1, W_NOARG},
        '{CMD_PEEK, 1'b1, 32'h0F0F_0F0F, 1'b0, W_NONE},
        '{CMD_POP,  1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_POP,  1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{CMD_POP,  1'b0, 32'h0000_0000, 1'b1, W_OK}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         cmd;
    logic               has_value;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic               has_data;
    logic signed [31:0] data;
    logic               last;

    // Pinned expectation travels with the input word
    logic               pin_now;
    word_t              pin_word;

    // Shadow stack and expected result words
    logic signed [31:0] shadow_stack [STACK_DEPTH];
    int                 shadow_count;
    word_t              pending_words [$];

    int                 mismatch_cnt;
    int                 commands_sent;
    int                 cycle_cnt;
    bit                 steady;     // no idling on either port
    bit                 hold_req;   // ask the receiver for a long hold

    stack_command_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .has_value (has_value),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .has_data  (has_data),
        .data      (data),
        .last      (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void post_word(input bit quiet, input logic [2:0] st,
                                      input logic hd, input logic signed [31:0] d,
                                      input logic lst);
        word_t w;
        w = '{st, hd, d, lst};
        if (!quiet)
            pending_words.push_back(w);
    endfunction

    // Apply one command to the shadow stack; quiet keeps the state update only
    function automatic void stack_apply(input logic [2:0] op, input logic hv,
                                        input logic signed [31:0] val, input bit quiet);
        int n;
        int k;
        logic signed [31:0] t;
        n = shadow_count;
        case (op)
            CMD_PUSH:
            begin
                if (!hv)
                    post_word(quiet, ST_NOARG, 1'b0, 32'sd0, 1'b1);
                else if (n >= STACK_DEPTH)
                    post_word(quiet, ST_FULL, 1'b0, 32'sd0, 1'b1);
                else
                begin
                    shadow_stack[n] = val;
                    shadow_count = n + 1;
                    post_word(quiet, ST_OK, 1'b0, 32'sd0, 1'b1);
                end
            end
            CMD_LIST:
            begin
                if (n == 0)
                    post_word(quiet, ST_OK, 1'b0, 32'sd0, 1'b1);
                for (k = n - 1; k >= 0; k--)
                    post_word(quiet, ST_OK, 1'b1, shadow_stack[k], k == 0);
            end
            CMD_PEEK:
            begin
                if (n == 0)
                    post_word(quiet, ST_EMPTY, 1'b0, 32'sd0, 1'b1);
                else
                    post_word(quiet, ST_OK, 1'b1, shadow_stack[n - 1], 1'b1);
            end
            CMD_POP:
            begin
                if (n == 0)
                    post_word(quiet, ST_EMPTY, 1'b0, 32'sd0, 1'b1);
                else
                begin
                    shadow_count = n - 1;
                    post_word(quiet, ST_OK, 1'b0, 32'sd0, 1'b1);
                end
            end
            CMD_SWAP:
            begin
                if (n < 2)
                    post_word(quiet, ST_SHORT, 1'b0, 32'sd0, 1'b1);
                else
                begin
                    t = shadow_stack[n - 1];
                    shadow_stack[n - 1] = shadow_stack[n - 2];
                    shadow_stack[n - 2] = t;
                    post_word(quiet, ST_OK, 1'b0, 32'sd0, 1'b1);
                end
            end
            default:
            begin
                // unused codes: no word, no change
            end
        endcase
    endfunction

    // Check output words first, then predict from the input word taken
    always @(posedge clk)
    begin
        word_t got;
        word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{status, has_data, data, last};
                if (pending_words.size() == 0)
                    report_mismatch("unexpected word", {28'd0, got.status, got.last},
                                    got.data);
                else
                begin
                    want = pending_words.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.has_data !== want.has_data)
                        report_mismatch("has_data", 32'(got.has_data),
                                        32'(want.has_data));
                    if (got.data !== want.data)
                        report_mismatch("data", got.data, want.data);
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                stack_apply(cmd, has_value, value, pin_now);
                if (pin_now)
                    pending_words.push_back(pin_word);
            end
        end
    end

    // Output side: random stall before each word, one long hold on request
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = steady ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Timeout
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Values weighted toward the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one command word after a random gap and wait until it is taken
    task automatic offer_word(input logic [2:0] op, input logic hv,
                              input logic signed [31:0] val, input logic pin,
                              input word_t want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        has_value <= hv;
        value     <= val;
        pin_now   <= pin;
        pin_word  <= want;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        commands_sent++;
    endtask

    // Stimulus
    initial
    begin
        int kind;
        int len;
        int r;
        logic [2:0] op;
        logic hv;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_PUSH;
        has_value     <= 1'b0;
        value         <= 32'sd0;
        pin_now       <= 1'b0;
        pin_word      <= W_NONE;
        shadow_count  = 0;
        mismatch_cnt  = 0;
        commands_sent = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening table: errors on empty, extremes, unused codes
        for (int i = 0; i < ROW_COUNT; i++)
            offer_word(OPENING_ROWS[i].op, OPENING_ROWS[i].hv, OPENING_ROWS[i].val,
                       OPENING_ROWS[i].pin, OPENING_ROWS[i].want);

        // Fill past full, then list the full stack under a long output hold
        for (int i = 0; i < STACK_DEPTH + 6; i++)
            offer_word(CMD_PUSH, 1'b1, pick_value(), 1'b0, W_NONE);
        hold_req = 1'b1;
        offer_word(CMD_LIST, 1'b0, pick_value(), 1'b0, W_NONE);
        for (int i = 0; i < 12; i++)
            offer_word(CMD_PUSH, 1'($urandom_range(0, 1)), pick_value(), 1'b0, W_NONE);
        offer_word(CMD_SWAP, 1'b0, pick_value(), 1'b0, W_NONE);
        offer_word(CMD_PEEK, 1'b1, pick_value(), 1'b0, W_NONE);
        offer_word(CMD_LIST, 1'b0, pick_value(), 1'b0, W_NONE);

        // Random rounds: growing, shrinking and unstructured
        while (commands_sent < COMMAND_TARGET)
        begin
            kind   = $urandom_range(0, 2);
            len    = $urandom_range(10, 40);
            steady = ($urandom_range(0, 3) == 0);
            repeat (len)
            begin
                r  = $urandom_range(0, 99);
                hv = ($urandom_range(0, 9) != 0);
                case (kind)
                    0:
                    begin
                        if (r < 65)      op = CMD_PUSH;
                        else if (r < 75) op = CMD_LIST;
                        else if (r < 85) op = CMD_PEEK;
                        else if (r < 92) op = CMD_SWAP;
                        else             op = CMD_POP;
                    end
                    1:
                    begin
                        if (r < 55)      op = CMD_POP;
                        else if (r < 70) op = CMD_PUSH;
                        else if (r < 80) op = CMD_PEEK;
                        else if (r < 90) op = CMD_SWAP;
                        else             op = CMD_LIST;
                    end
                    default:
                    begin
                        op = 3'($urandom_range(0, 7));
                        hv = 1'($urandom_range(0, 1));
                    end
                endcase
                offer_word(op, hv, pick_value(), 1'b0, W_NONE);
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain
        while (pending_words.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
